// ===== design/ipv4_five_tuple_header_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ipv4 five-tuple parser assertion macros
// clocked implication checks, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef IPV4_FIVE_TUPLE_HEADER_PARSER_UNIT_ASSERT_SVH
`define IPV4_FIVE_TUPLE_HEADER_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define IPV4FT_ASSERT_SAME(name, clock, resetn, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPV4FT_ASSERT_NEXT(name, clock, resetn, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ipv4ft_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4ft_pkg
// shared types and constants of the ipv4 five-tuple header parser
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4ft_pkg;

  localparam int COUNT_BITS = 16;
  localparam int LEN_W      = 16;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LEN_W-1:0]      flen_t;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [2:0]  KIND_OUTGOING  = 3'd4;

  localparam int ETH_LEN    = 14;
  localparam int IP_MIN_LEN = 20;
  localparam int TCP_LEN    = 20;
  localparam int UDP_LEN    = 8;

  localparam int POS_ETYPE_HI  = 12;
  localparam int POS_ETYPE_LO  = 13;
  localparam int POS_VER_IHL   = 14;
  localparam int POS_PROTO     = 23;
  localparam int POS_SRC_FIRST = 26;
  localparam int POS_SRC_LAST  = 29;
  localparam int POS_DST_FIRST = 30;
  localparam int POS_DST_LAST  = 33;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_NOT_IPV4    = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_IHL     = 3'd4,
    ST_NOT_L4      = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
    logic [2:0] packet_kind;
  } beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol;
    flen_t       frame_length;
    logic        outgoing;
  } result_t;

endpackage

`default_nettype wire

// ===== design/ipv4ft_in_if.sv =====
// ----------------------------------------------------------------------------
// ipv4ft_in_if
// byte stream channel into the parser, one frame byte per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4ft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;
  logic [2:0] packet_kind;

  modport source (output valid, output data_byte, output end_of_frame,
                  output packet_kind, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame,
                  input packet_kind, output ready);
endinterface

`default_nettype wire

// ===== design/ipv4ft_out_if.sv =====
// ----------------------------------------------------------------------------
// ipv4ft_out_if
// per-frame record channel out of the parser, one record per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4ft_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  protocol;
  logic [15:0] frame_length;
  logic        outgoing;

  modport source (output valid, output status, output source_address,
                  output dest_address, output source_port, output dest_port,
                  output protocol, output frame_length, output outgoing,
                  input ready);
  modport sink   (input valid, input status, input source_address,
                  input dest_address, input source_port, input dest_port,
                  input protocol, input frame_length, input outgoing,
                  output ready);
endinterface

`default_nettype wire

// ===== design/ipv4ft_frame_parser.sv =====
// ----------------------------------------------------------------------------
// ipv4ft_frame_parser
// per-frame field capture and classification, record on the last byte
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4ft_frame_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               beat_fire,
  input  wire ipv4ft_pkg::beat_t  beat,
  output logic                    res_valid,
  output ipv4ft_pkg::result_t     res
);

  ipv4ft_pkg::count_t byte_idx_r, byte_idx_nxt;
  logic [15:0]        etype_r, etype_nxt;
  logic [7:0]         ver_ihl_r, ver_ihl_nxt;
  logic [7:0]         proto_r, proto_nxt;
  logic [31:0]        src_r, src_nxt;
  logic [31:0]        dst_r, dst_nxt;
  logic [15:0]        sport_r, sport_nxt;
  logic [15:0]        dport_r, dport_nxt;

  ipv4ft_pkg::count_t pos;
  ipv4ft_pkg::count_t l4;
  ipv4ft_pkg::count_t len;
  ipv4ft_pkg::count_t need;
  logic [5:0]         ihl_bytes;
  logic [7:0]         b;
  ipv4ft_pkg::status_t st;

  assign pos = byte_idx_r;
  assign b   = beat.data_byte;
  // port offset uses the header length known before this byte
  assign l4  = ipv4ft_pkg::count_t'(ipv4ft_pkg::ETH_LEN)
             + ipv4ft_pkg::count_t'({ver_ihl_r[3:0], 2'b00});

  always_comb begin
    etype_nxt   = etype_r;
    ver_ihl_nxt = ver_ihl_r;
    proto_nxt   = proto_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    sport_nxt   = sport_r;
    dport_nxt   = dport_r;
    if (pos == ipv4ft_pkg::count_t'(ipv4ft_pkg::POS_ETYPE_HI)) etype_nxt[15:8] = b;
    if (pos == ipv4ft_pkg::count_t'(ipv4ft_pkg::POS_ETYPE_LO)) etype_nxt[7:0] = b;
    if (pos == ipv4ft_pkg::count_t'(ipv4ft_pkg::POS_VER_IHL)) ver_ihl_nxt = b;
    if (pos == ipv4ft_pkg::count_t'(ipv4ft_pkg::POS_PROTO)) proto_nxt = b;
    if (pos >= ipv4ft_pkg::count_t'(ipv4ft_pkg::POS_SRC_FIRST) &&
        pos <= ipv4ft_pkg::count_t'(ipv4ft_pkg::POS_SRC_LAST)) begin
      src_nxt = {src_r[23:0], b};
    end
    if (pos >= ipv4ft_pkg::count_t'(ipv4ft_pkg::POS_DST_FIRST) &&
        pos <= ipv4ft_pkg::count_t'(ipv4ft_pkg::POS_DST_LAST)) begin
      dst_nxt = {dst_r[23:0], b};
    end
    if (pos == l4) sport_nxt[15:8] = b;
    if (pos == l4 + ipv4ft_pkg::count_t'(1)) sport_nxt[7:0] = b;
    if (pos == l4 + ipv4ft_pkg::count_t'(2)) dport_nxt[15:8] = b;
    if (pos == l4 + ipv4ft_pkg::count_t'(3)) dport_nxt[7:0] = b;
    byte_idx_nxt = (&byte_idx_r) ? byte_idx_r : byte_idx_r + ipv4ft_pkg::count_t'(1);
  end

  assign len       = byte_idx_nxt;
  assign ihl_bytes = {ver_ihl_nxt[3:0], 2'b00};
  assign need      = ipv4ft_pkg::count_t'(ipv4ft_pkg::ETH_LEN)
                   + ipv4ft_pkg::count_t'(ihl_bytes)
                   + ((proto_nxt == ipv4ft_pkg::PROTO_TCP)
                      ? ipv4ft_pkg::count_t'(ipv4ft_pkg::TCP_LEN)
                      : ipv4ft_pkg::count_t'(ipv4ft_pkg::UDP_LEN));

  always_comb begin
    if (len < ipv4ft_pkg::count_t'(ipv4ft_pkg::ETH_LEN)) begin
      st = ipv4ft_pkg::ST_TOO_SHORT;
    end else if (etype_nxt != ipv4ft_pkg::ETHERTYPE_IPV4) begin
      st = ipv4ft_pkg::ST_NOT_IPV4;
    end else if (len < ipv4ft_pkg::count_t'(ipv4ft_pkg::ETH_LEN + ipv4ft_pkg::IP_MIN_LEN)) begin
      st = ipv4ft_pkg::ST_TOO_SHORT;
    end else if (ver_ihl_nxt[7:4] != ipv4ft_pkg::IP_VERSION_4) begin
      st = ipv4ft_pkg::ST_BAD_VERSION;
    end else if (ihl_bytes < 6'(ipv4ft_pkg::IP_MIN_LEN)) begin
      st = ipv4ft_pkg::ST_BAD_IHL;
    end else if (!(proto_nxt inside {ipv4ft_pkg::PROTO_TCP, ipv4ft_pkg::PROTO_UDP})) begin
      st = ipv4ft_pkg::ST_NOT_L4;
    end else if (len < need) begin
      st = ipv4ft_pkg::ST_TOO_SHORT;
    end else begin
      st = ipv4ft_pkg::ST_ACCEPTED;
    end
  end

  always_comb begin
    res.status         = st;
    res.source_address = (st == ipv4ft_pkg::ST_ACCEPTED) ? src_nxt : '0;
    res.dest_address   = (st == ipv4ft_pkg::ST_ACCEPTED) ? dst_nxt : '0;
    res.source_port    = (st == ipv4ft_pkg::ST_ACCEPTED) ? sport_nxt : '0;
    res.dest_port      = (st == ipv4ft_pkg::ST_ACCEPTED) ? dport_nxt : '0;
    res.protocol       = (st == ipv4ft_pkg::ST_ACCEPTED) ? proto_nxt : '0;
    res.frame_length   = ((len >> ipv4ft_pkg::LEN_W) != '0) ? '1
                       : ipv4ft_pkg::LEN_W'(len);
    res.outgoing       = (beat.packet_kind == ipv4ft_pkg::KIND_OUTGOING);
  end

  assign res_valid = beat_fire && beat.end_of_frame;

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      byte_idx_r <= '0;
      etype_r    <= '0;
      ver_ihl_r  <= '0;
      proto_r    <= '0;
      src_r      <= '0;
      dst_r      <= '0;
      sport_r    <= '0;
      dport_r    <= '0;
    end else if (beat_fire) begin
      byte_idx_r <= byte_idx_nxt;
      etype_r    <= etype_nxt;
      ver_ihl_r  <= ver_ihl_nxt;
      proto_r    <= proto_nxt;
      src_r      <= src_nxt;
      dst_r      <= dst_nxt;
      sport_r    <= sport_nxt;
      dport_r    <= dport_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/ipv4_five_tuple_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ipv4_five_tuple_header_parser_unit
// ethernet/ipv4 tcp-udp five-tuple extraction from a byte stream
//
// in_bus carries one frame byte per beat, starting at the destination mac;
// end_of_frame marks the last byte and packet_kind is sampled on it.
// out_bus carries one record per frame: status, addresses, ports, protocol,
// saturated frame length and outgoing flag; flow fields are zero unless
// the status is accepted.
// throughput: one byte per cycle, sustained across frame boundaries unless a last byte waits on a stalled out_bus.
// the path is an input register, capture and classify logic, and a result
// register; a finished record waits in the result register while bytes
// of the next frame keep flowing, and only a second last byte holds off
// in_bus.ready while out_bus is stalled.
// reset (rst_n low, synchronous) empties both registers and clears all
// per-frame capture state; the first byte after reset starts a frame.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_five_tuple_header_parser_unit_assert.svh"

module ipv4_five_tuple_header_parser_unit (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ipv4ft_in_if.sink     in_bus,
  ipv4ft_out_if.source  out_bus
);

  ipv4ft_pkg::beat_t   beat_r;
  logic                s1_valid_r, s1_valid_nxt;
  ipv4ft_pkg::result_t res_r;
  logic                out_valid_r, out_valid_nxt;

  logic                out_stall;
  logic                s1_fire;
  logic                in_ready;
  logic                in_fire;
  logic                res_valid;
  ipv4ft_pkg::result_t res;

  assign out_stall = out_valid_r && !out_bus.ready;
  assign s1_fire   = s1_valid_r && !(beat_r.end_of_frame && out_stall);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_fire   = in_bus.valid && in_ready;

  assign in_bus.ready = in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      beat_r.data_byte    <= in_bus.data_byte;
      beat_r.end_of_frame <= in_bus.end_of_frame;
      beat_r.packet_kind  <= in_bus.packet_kind;
    end
    if (res_valid) begin
      res_r <= res;
    end
  end

  ipv4ft_frame_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_fire (s1_fire),
    .beat      (beat_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_bus.valid          = out_valid_r;
  assign out_bus.status         = res_r.status;
  assign out_bus.source_address = res_r.source_address;
  assign out_bus.dest_address   = res_r.dest_address;
  assign out_bus.source_port    = res_r.source_port;
  assign out_bus.dest_port      = res_r.dest_port;
  assign out_bus.protocol       = res_r.protocol;
  assign out_bus.frame_length   = res_r.frame_length;
  assign out_bus.outgoing       = res_r.outgoing;

  `IPV4FT_ASSERT_SAME(a_rec_from_last_beat, clk, rst_n, $rose(out_valid_r), $past(s1_valid_r && beat_r.end_of_frame), "record without a last byte")
  `IPV4FT_ASSERT_NEXT(a_held_beat_kept, clk, rst_n, s1_valid_r && !s1_fire, s1_valid_r && $stable(beat_r), "held byte lost")
  `IPV4FT_ASSERT_SAME(a_reject_zeroed, clk, rst_n, out_valid_r && res_r.status != ipv4ft_pkg::ST_ACCEPTED, res_r.source_address == '0 && res_r.dest_address == '0 && res_r.source_port == '0 && res_r.dest_port == '0 && res_r.protocol == '0, "rejected record carries flow fields")
  `IPV4FT_ASSERT_SAME(a_accept_l4, clk, rst_n, out_valid_r && res_r.status == ipv4ft_pkg::ST_ACCEPTED, res_r.protocol == ipv4ft_pkg::PROTO_TCP || res_r.protocol == ipv4ft_pkg::PROTO_UDP, "accepted record not tcp or udp")

endmodule

`default_nettype wire
